// File: hw/rtl/tnt_pkg.sv
// shared types, constants and helper functions of the triangle normal and tangent unit
package tnt_pkg;

  localparam int MagW = 62;
  localparam logic [MagW-1:0] FitLimit = MagW'(64'd1 << 30);

  typedef logic [MagW-1:0] mag_t;

  typedef struct packed {
    logic neg;
    mag_t mag;
  } sm_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
  } vertex_t;

  typedef struct packed {
    logic start;
    logic need_face;
  } calc_req_t;

  typedef struct packed {
    logic             done;
    logic [2:0][15:0] tan;
    logic [2:0][15:0] face;
  } calc_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FIT_E, ST_FIT_UV, ST_MUL, ST_ACC, ST_FIT_W,
    ST_SQRT, ST_DIVLD, ST_DIV, ST_FIT_AB
  } calc_state_t;

  typedef enum logic [1:0] {
    MM_TAN, MM_NRM, MM_SQ
  } mul_mode_t;

  typedef enum logic [1:0] {
    TS_COLLECT, TS_CALC, TS_OUT
  } top_state_t;

  function automatic sm_t sm_diff(input logic signed [31:0] a, input logic signed [31:0] b);
    logic [32:0] d;
    logic [32:0] m;
    sm_t         r;
    d = {a[31], a} - {b[31], b};
    m = d[32] ? (33'd0 - d) : d;
    r.neg = d[32];
    r.mag = MagW'(m);
    return r;
  endfunction

  function automatic sm_t sm_of64(input logic signed [63:0] v);
    logic [63:0] m;
    sm_t         r;
    m = v[63] ? (64'd0 - v) : v;
    r.neg = v[63];
    r.mag = m[MagW-1:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sm_to32(input sm_t s);
    logic signed [31:0] m;
    m = {1'b0, s.mag[30:0]};
    return s.neg ? -m : m;
  endfunction

  // operand slots: 0..5 edge components, 6..9 uv deltas
  function automatic logic [3:0] mul_sel_a(input mul_mode_t mode, input logic [2:0] step);
    logic [3:0] r;
    r = 4'd0;
    if (mode == MM_TAN) begin
      case (step)
        3'd0: r = 4'd6;
        3'd1: r = 4'd7;
        3'd2, 3'd4, 3'd6: r = 4'd9;
        default: r = 4'd7;
      endcase
    end else begin
      case (step)
        3'd0: r = 4'd1;
        3'd1: r = 4'd2;
        3'd2: r = 4'd2;
        3'd3: r = 4'd0;
        3'd4: r = 4'd0;
        default: r = 4'd1;
      endcase
    end
    return r;
  endfunction

  function automatic logic [3:0] mul_sel_b(input mul_mode_t mode, input logic [2:0] step);
    logic [3:0] r;
    r = 4'd0;
    if (mode == MM_TAN) begin
      case (step)
        3'd0: r = 4'd9;
        3'd1: r = 4'd8;
        3'd2: r = 4'd0;
        3'd3: r = 4'd3;
        3'd4: r = 4'd1;
        3'd5: r = 4'd4;
        3'd6: r = 4'd2;
        default: r = 4'd5;
      endcase
    end else begin
      case (step)
        3'd0: r = 4'd5;
        3'd1: r = 4'd4;
        3'd2: r = 4'd3;
        3'd3: r = 4'd5;
        3'd4: r = 4'd4;
        default: r = 4'd3;
      endcase
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/tnt_if.sv
// vertex input and output channel interfaces
interface tnt_vtx_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] tex_u;
  logic signed [31:0] tex_v;
  logic               has_normal;
  logic signed [15:0] norm_in_x;
  logic signed [15:0] norm_in_y;
  logic signed [15:0] norm_in_z;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, has_normal,
                  norm_in_x, norm_in_y, norm_in_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, has_normal,
                norm_in_x, norm_in_y, norm_in_z, output ready);
endinterface

interface tnt_vtx_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_pos_z;
  logic signed [31:0] out_tex_u;
  logic signed [31:0] out_tex_v;
  logic signed [15:0] out_norm_x;
  logic signed [15:0] out_norm_y;
  logic signed [15:0] out_norm_z;
  logic signed [15:0] tangent_x;
  logic signed [15:0] tangent_y;
  logic signed [15:0] tangent_z;
  logic               last_of_triangle;

  modport source (output valid, out_pos_x, out_pos_y, out_pos_z, out_tex_u, out_tex_v,
                  out_norm_x, out_norm_y, out_norm_z, tangent_x, tangent_y, tangent_z,
                  last_of_triangle, input ready);
  modport sink (input valid, out_pos_x, out_pos_y, out_pos_z, out_tex_u, out_tex_v,
                out_norm_x, out_norm_y, out_norm_z, tangent_x, tangent_y, tangent_z,
                last_of_triangle, output ready);
endinterface

// File: hw/rtl/triangle_normal_tangent_unit.sv
// triangle vertex buffer, result sequencing and top level of the normal and tangent unit
// first two vertices of a triangle: stored in the vertex buffer, no result
// third vertex: starts the tangent, and a face normal when a corner lacks a normal; block scaling
//   halves oversized groups first, and a zero perp-dot or zero length skips a part; the work is
//   done by the shared multiplier, the 32-step square root and the 45-step divider per component
// the three results then leave at one per cycle while the sink is ready; no input meanwhile
// synchronous active-high reset clears the corner count, missing-normal flag and sequencers
module triangle_normal_tangent_unit import tnt_pkg::*; (
  input logic          clk,
  input logic          rst,
  tnt_vtx_in_if.sink   vtx_in,
  tnt_vtx_out_if.source vtx_out
);

  top_state_t state, state_next;
  vertex_t    vtx [3];
  logic [1:0] corner_count;
  logic       normal_missing;
  logic       need_face;
  logic [1:0] out_idx;
  calc_req_t  req;
  calc_rsp_t  rsp;
  logic       in_xfer, out_xfer;
  vertex_t    cur;

  assign vtx_in.ready = (state == TS_COLLECT);
  assign in_xfer      = vtx_in.valid && vtx_in.ready;
  assign out_xfer     = vtx_out.valid && vtx_out.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      TS_COLLECT: if (in_xfer && corner_count[1]) state_next = TS_CALC;
      TS_CALC:    if (rsp.done) state_next = TS_OUT;
      TS_OUT:     if (out_xfer && out_idx == 2'd2) state_next = TS_COLLECT;
      default:    state_next = TS_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= TS_COLLECT;
      corner_count   <= 2'd0;
      normal_missing <= 1'b0;
      req            <= '0;
      out_idx        <= 2'd0;
    end else begin
      state     <= state_next;
      req.start <= in_xfer && corner_count[1];
      if (in_xfer) begin
        if (corner_count[1]) begin
          corner_count   <= 2'd0;
          normal_missing <= 1'b0;
          req.need_face  <= normal_missing || !vtx_in.has_normal;
        end else begin
          corner_count   <= corner_count + 2'd1;
          normal_missing <= normal_missing || !vtx_in.has_normal;
        end
      end
      if (state == TS_CALC) out_idx <= 2'd0;
      else if (out_xfer) out_idx <= out_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      vtx[corner_count[1] ? 2'd2 : corner_count] <= '{
        pos_x: vtx_in.pos_x, pos_y: vtx_in.pos_y, pos_z: vtx_in.pos_z,
        tex_u: vtx_in.tex_u, tex_v: vtx_in.tex_v,
        norm_x: vtx_in.norm_in_x, norm_y: vtx_in.norm_in_y, norm_z: vtx_in.norm_in_z};
    end
    if (req.start) need_face <= req.need_face;
  end

  tnt_calc u_calc (
    .clk (clk),
    .rst (rst),
    .req (req),
    .v0  (vtx[0]),
    .v1  (vtx[1]),
    .v2  (vtx[2]),
    .rsp (rsp)
  );

  assign cur = vtx[out_idx];

  assign vtx_out.valid            = (state == TS_OUT);
  assign vtx_out.out_pos_x        = cur.pos_x;
  assign vtx_out.out_pos_y        = cur.pos_y;
  assign vtx_out.out_pos_z        = cur.pos_z;
  assign vtx_out.out_tex_u        = cur.tex_u;
  assign vtx_out.out_tex_v        = cur.tex_v;
  assign vtx_out.out_norm_x       = need_face ? rsp.face[0] : cur.norm_x;
  assign vtx_out.out_norm_y       = need_face ? rsp.face[1] : cur.norm_y;
  assign vtx_out.out_norm_z       = need_face ? rsp.face[2] : cur.norm_z;
  assign vtx_out.tangent_x        = rsp.tan[0];
  assign vtx_out.tangent_y        = rsp.tan[1];
  assign vtx_out.tangent_z        = rsp.tan[2];
  assign vtx_out.last_of_triangle = (out_idx == 2'd2);

endmodule

// File: hw/rtl/tnt_calc.sv
// sequenced shared multiplier, square root and divider for tangent and face normal
module tnt_calc import tnt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  calc_req_t req,
  input  vertex_t   v0,
  input  vertex_t   v1,
  input  vertex_t   v2,
  output calc_rsp_t rsp
);

  calc_state_t        state, state_next;
  sm_t                wk [6];
  logic signed [31:0] fv [10];
  mul_mode_t          mode;
  logic [2:0]         step;
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic signed [63:0] res [4];
  logic               face_tgt;
  logic               need_face;
  logic [63:0]        sq_x;
  logic [63:0]        sq_r;
  logic [4:0]         sq_i;
  logic [1:0]         comp;
  logic [44:0]        num;
  logic [31:0]        rem;
  logic [15:0]        quo;
  logic [5:0]         div_cnt;
  logic [2:0][15:0]   tan;
  logic [2:0][15:0]   face;
  logic               done;

  logic               over;
  logic               last_step;
  logic               first_step;
  logic signed [63:0] acc_new;
  logic signed [31:0] opa, opb;
  logic [63:0]        sq_bit, sq_try;
  logic [32:0]        div_r2;
  logic               div_ge;
  logic [15:0]        q_fin;
  logic               q_neg;
  logic signed [15:0] q_val;
  logic               unit_end;

  always_comb begin
    over = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (wk[i].mag > FitLimit) over = 1'b1;
    end
  end

  always_comb begin
    unique case (mode)
      MM_TAN:  last_step = (step == 3'd7);
      MM_NRM:  last_step = (step == 3'd5);
      MM_SQ:   last_step = (step == 3'd2);
      default: last_step = 1'b1;
    endcase
    first_step = (mode == MM_SQ) ? (step == 3'd0) : !step[0];
    if (first_step) acc_new = prod;
    else if (mode == MM_SQ) acc_new = acc + prod;
    else acc_new = acc - prod;
    if (mode == MM_SQ) begin
      opa = sm_to32('{neg: 1'b0, mag: wk[step].mag});
      opb = opa;
    end else begin
      opa = fv[mul_sel_a(mode, step)];
      opb = fv[mul_sel_b(mode, step)];
    end
  end

  always_comb begin
    sq_bit = 64'd1 << {sq_i, 1'b0};
    sq_try = sq_r + sq_bit;
    div_r2 = {rem, num[44]};
    div_ge = div_r2 >= {1'b0, sq_r[31:0]};
    q_fin  = {quo[14:0], div_ge};
    q_neg  = wk[{1'b0, comp}].neg ^ (!face_tgt & res[0][63]);
    q_val  = q_neg ? -$signed(q_fin) : $signed(q_fin);
  end

  // end of a tangent or face unit vector, zero or not
  always_comb begin
    unit_end = 1'b0;
    if (state == ST_ACC && last_step) begin
      if (mode == MM_TAN && res[0] == 64'sd0) unit_end = 1'b1;
      if (mode == MM_SQ && acc_new == 64'sd0) unit_end = 1'b1;
    end
    if (state == ST_DIV && div_cnt == 6'd0 && comp == 2'd2) unit_end = 1'b1;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (req.start) state_next = ST_FIT_E;
      ST_FIT_E:  if (!over) state_next = ST_FIT_UV;
      ST_FIT_UV: if (!over) state_next = ST_MUL;
      ST_MUL:    state_next = ST_ACC;
      ST_ACC: begin
        if (!last_step) state_next = ST_MUL;
        else if (mode == MM_SQ && !unit_end) state_next = ST_SQRT;
        else if (mode != MM_SQ && !unit_end) state_next = ST_FIT_W;
        else if (!face_tgt && need_face) state_next = ST_FIT_AB;
        else state_next = ST_IDLE;
      end
      ST_FIT_W:  if (!over) state_next = ST_MUL;
      ST_SQRT:   if (sq_i == 5'd0) state_next = ST_DIVLD;
      ST_DIVLD:  state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == 6'd0) begin
          if (comp != 2'd2) state_next = ST_DIVLD;
          else if (!face_tgt && need_face) state_next = ST_FIT_AB;
          else state_next = ST_IDLE;
        end
      end
      ST_FIT_AB: if (!over) state_next = ST_MUL;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state != ST_IDLE) && (state_next == ST_IDLE);
    end
  end

  // working vector: load, block scaling
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.start) begin
      wk[0] <= sm_diff(v1.pos_x, v0.pos_x);
      wk[1] <= sm_diff(v1.pos_y, v0.pos_y);
      wk[2] <= sm_diff(v1.pos_z, v0.pos_z);
      wk[3] <= sm_diff(v2.pos_x, v0.pos_x);
      wk[4] <= sm_diff(v2.pos_y, v0.pos_y);
      wk[5] <= sm_diff(v2.pos_z, v0.pos_z);
    end else if (state == ST_FIT_E && !over) begin
      wk[0] <= sm_diff(v1.tex_u, v0.tex_u);
      wk[1] <= sm_diff(v1.tex_v, v0.tex_v);
      wk[2] <= sm_diff(v2.tex_u, v0.tex_u);
      wk[3] <= sm_diff(v2.tex_v, v0.tex_v);
      wk[4] <= '0;
      wk[5] <= '0;
    end else if (state != ST_FIT_AB && state_next == ST_FIT_AB) begin
      wk[0] <= sm_diff(v1.pos_x, v2.pos_x);
      wk[1] <= sm_diff(v1.pos_y, v2.pos_y);
      wk[2] <= sm_diff(v1.pos_z, v2.pos_z);
      wk[3] <= sm_diff(v0.pos_x, v1.pos_x);
      wk[4] <= sm_diff(v0.pos_y, v1.pos_y);
      wk[5] <= sm_diff(v0.pos_z, v1.pos_z);
    end else if (state == ST_ACC && state_next == ST_FIT_W) begin
      wk[0] <= sm_of64(res[1]);
      wk[1] <= sm_of64(res[2]);
      wk[2] <= sm_of64(acc_new);
      wk[3] <= '0;
      wk[4] <= '0;
      wk[5] <= '0;
    end else if (over && (state == ST_FIT_E || state == ST_FIT_UV ||
                          state == ST_FIT_W || state == ST_FIT_AB)) begin
      for (int i = 0; i < 6; i++) wk[i].mag <= wk[i].mag >> 1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req.start) begin
          need_face <= req.need_face;
          face_tgt  <= 1'b0;
          tan       <= '0;
          face      <= '0;
        end
      end
      ST_FIT_E: begin
        if (!over) for (int i = 0; i < 6; i++) fv[i] <= sm_to32(wk[i]);
      end
      ST_FIT_UV: begin
        if (!over) begin
          for (int i = 0; i < 4; i++) fv[6 + i] <= sm_to32(wk[i]);
          mode <= MM_TAN;
          step <= 3'd0;
        end
      end
      ST_FIT_W: begin
        if (!over) begin
          mode <= MM_SQ;
          step <= 3'd0;
        end
      end
      ST_FIT_AB: begin
        if (!over) begin
          for (int i = 0; i < 6; i++) fv[i] <= sm_to32(wk[i]);
          mode     <= MM_NRM;
          step     <= 3'd0;
          face_tgt <= 1'b1;
        end
      end
      ST_MUL: prod <= opa * opb;
      ST_ACC: begin
        acc  <= acc_new;
        step <= step + 3'd1;
        if (mode == MM_TAN && step[0]) res[step[2:1]] <= acc_new;
        if (mode == MM_NRM && step[0]) res[2'(step[2:1] + 2'd1)] <= acc_new;
        if (mode == MM_SQ && last_step) begin
          sq_x <= unsigned'(acc_new);
          sq_r <= '0;
          sq_i <= 5'd31;
          comp <= 2'd0;
        end
      end
      ST_SQRT: begin
        if (sq_x >= sq_try) begin
          sq_x <= sq_x - sq_try;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_i <= sq_i - 5'd1;
      end
      ST_DIVLD: begin
        num     <= {wk[{1'b0, comp}].mag[30:0], 14'd0} + 45'(sq_r[31:1]);
        rem     <= '0;
        quo     <= '0;
        div_cnt <= 6'd44;
      end
      ST_DIV: begin
        rem     <= div_ge ? 32'(div_r2 - {1'b0, sq_r[31:0]}) : div_r2[31:0];
        quo     <= q_fin;
        num     <= num << 1;
        div_cnt <= div_cnt - 6'd1;
        if (div_cnt == 6'd0) begin
          if (face_tgt) face[comp] <= q_val;
          else tan[comp] <= q_val;
          comp <= comp + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign rsp.done = done;
  assign rsp.tan  = tan;
  assign rsp.face = face;

endmodule

// File: hw/rtl/tnt_checker.sv
// port-level checks of the normal and tangent unit and their binding
module tnt_assertions (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_last,
  input logic [15:0] tangent_x
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped before transfer");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while results pending");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("result after last of triangle");

  a_tan_shared: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> $stable(tangent_x))
    else $error("tangent changed within a triangle");

endmodule

bind triangle_normal_tangent_unit tnt_assertions u_tnt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (vtx_in.ready),
  .out_valid (vtx_out.valid),
  .out_ready (vtx_out.ready),
  .out_last  (vtx_out.last_of_triangle),
  .tangent_x (vtx_out.tangent_x)
);

// File: tb/tnt_checker.sv
// checker: predicts triangle results from accepted vertices and compares them with the output
`timescale 1ns / 1ps
module tnt_checker (
  input logic      clk,
  input logic      rst,
  tnt_vtx_in_if    vtx_in,
  tnt_vtx_out_if   vtx_out,
  output int       fail_count,
  output int       pending,
  output int       vertex_total
);

  typedef struct packed {
    logic signed [31:0] px, py, pz, tu, tv;
    logic signed [15:0] nx, ny, nz, tx, ty, tz;
    logic               last;
  } vtx_result_t;

  typedef struct {
    logic signed [31:0] px, py, pz, tu, tv;
    logic signed [15:0] nx, ny, nz;
  } corner_t;

  vtx_result_t result_fifo[$];
  corner_t     corners[2];
  int          corner_idx;
  logic        lacks_normal;

  function automatic longint magof(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void scale_group(ref longint v[6], input int n);
    longint mx;
    int     s;
    mx = 0;
    s = 0;
    for (int i = 0; i < n; i++) if (magof(v[i]) > mx) mx = magof(v[i]);
    while (s < 63 && (mx >>> s) > (64'sd1 <<< 30)) s++;
    for (int i = 0; i < n; i++) v[i] = v[i] < 0 ? -(magof(v[i]) >>> s) : (v[i] >>> s);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void unit_vector(input longint w[3], output logic signed [15:0] u[3]);
    longint      c[6];
    logic [63:0] sum, len, q, m;
    for (int i = 0; i < 3; i++) c[i] = w[i];
    for (int i = 3; i < 6; i++) c[i] = 0;
    scale_group(c, 3);
    sum = 0;
    for (int i = 0; i < 3; i++) sum += magof(c[i]) * magof(c[i]);
    if (sum == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return;
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      m = magof(c[i]);
      q = (m * 16384 + len / 2) / len;
      u[i] = c[i] < 0 ? 16'(-q) : 16'(q);
    end
  endfunction

  task automatic predict_triangle(corner_t p2);
    corner_t            k[3];
    longint             e[6], uv[6], ab[6], w[3], pd;
    logic signed [15:0] tng[3], face[3];
    vtx_result_t        r;
    k[0] = corners[0];
    k[1] = corners[1];
    k[2] = p2;
    e[0] = longint'(k[1].px) - k[0].px; e[1] = longint'(k[1].py) - k[0].py;
    e[2] = longint'(k[1].pz) - k[0].pz; e[3] = longint'(k[2].px) - k[0].px;
    e[4] = longint'(k[2].py) - k[0].py; e[5] = longint'(k[2].pz) - k[0].pz;
    uv[0] = longint'(k[1].tu) - k[0].tu; uv[1] = longint'(k[1].tv) - k[0].tv;
    uv[2] = longint'(k[2].tu) - k[0].tu; uv[3] = longint'(k[2].tv) - k[0].tv;
    uv[4] = 0; uv[5] = 0;
    scale_group(e, 6);
    scale_group(uv, 4);
    pd = uv[0] * uv[3] - uv[1] * uv[2];
    for (int c = 0; c < 3; c++) w[c] = uv[3] * e[c] - uv[1] * e[3 + c];
    if (pd == 0) begin
      for (int c = 0; c < 3; c++) tng[c] = 0;
    end else begin
      unit_vector(w, tng);
      if (pd < 0) for (int c = 0; c < 3; c++) tng[c] = -tng[c];
    end
    if (lacks_normal) begin
      ab[0] = longint'(k[1].px) - k[2].px; ab[1] = longint'(k[1].py) - k[2].py;
      ab[2] = longint'(k[1].pz) - k[2].pz; ab[3] = longint'(k[0].px) - k[1].px;
      ab[4] = longint'(k[0].py) - k[1].py; ab[5] = longint'(k[0].pz) - k[1].pz;
      scale_group(ab, 6);
      w[0] = ab[1] * ab[5] - ab[2] * ab[4];
      w[1] = ab[2] * ab[3] - ab[0] * ab[5];
      w[2] = ab[0] * ab[4] - ab[1] * ab[3];
      unit_vector(w, face);
    end
    for (int i = 0; i < 3; i++) begin
      r.px = k[i].px; r.py = k[i].py; r.pz = k[i].pz;
      r.tu = k[i].tu; r.tv = k[i].tv;
      r.nx = lacks_normal ? face[0] : k[i].nx;
      r.ny = lacks_normal ? face[1] : k[i].ny;
      r.nz = lacks_normal ? face[2] : k[i].nz;
      r.tx = tng[0]; r.ty = tng[1]; r.tz = tng[2];
      r.last = (i == 2);
      result_fifo.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    corner_t     cin;
    vtx_result_t got, want;
    if (rst) begin
      corner_idx <= 0;
      lacks_normal = 0;
      fail_count <= 0;
      vertex_total <= 0;
      result_fifo.delete();
    end else begin
      if (vtx_out.valid && vtx_out.ready) begin
        got = '{vtx_out.out_pos_x, vtx_out.out_pos_y, vtx_out.out_pos_z, vtx_out.out_tex_u,
                vtx_out.out_tex_v, vtx_out.out_norm_x, vtx_out.out_norm_y,
                vtx_out.out_norm_z, vtx_out.tangent_x, vtx_out.tangent_y,
                vtx_out.tangent_z, vtx_out.last_of_triangle};
        vertex_total <= vertex_total + 1;
        if (result_fifo.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected output transfer %p", got);
        end else begin
          want = result_fifo.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("mismatch\n  expected %p\n  actual   %p", want, got);
          end
        end
      end
      if (vtx_in.valid && vtx_in.ready) begin
        cin = '{vtx_in.pos_x, vtx_in.pos_y, vtx_in.pos_z, vtx_in.tex_u, vtx_in.tex_v,
                vtx_in.norm_in_x, vtx_in.norm_in_y, vtx_in.norm_in_z};
        if (!vtx_in.has_normal) lacks_normal = 1;
        if (corner_idx < 2) begin
          corners[corner_idx] = cin;
          corner_idx <= corner_idx + 1;
        end else begin
          predict_triangle(cin);
          corner_idx <= 0;
          lacks_normal = 0;
        end
      end
    end
  end

  assign pending = result_fifo.size();

endmodule

// File: tb/testbench.sv
// testbench top: vertex stimulus, output stalls and the final verdict
`timescale 1ns / 1ps
module testbench;

  logic clk;
  logic rst;
  int   fail_count, pending, vertex_total;
  int   sent;
  bit   calm;

  tnt_vtx_in_if  vtx_in();
  tnt_vtx_out_if vtx_out();

  triangle_normal_tangent_unit dut (.clk(clk), .rst(rst), .vtx_in(vtx_in), .vtx_out(vtx_out));
  tnt_checker checker_i (.clk(clk), .rst(rst), .vtx_in(vtx_in), .vtx_out(vtx_out),
                         .fail_count(fail_count), .pending(pending),
                         .vertex_total(vertex_total));

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] rand_word(int style);
    case (style)
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      default: return 32'($signed($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  task automatic send_vertex(logic [31:0] px, py, pz, tu, tv, logic hn,
                             logic [15:0] nx, ny, nz);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      vtx_in.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    vtx_in.valid <= 1;
    vtx_in.pos_x <= px; vtx_in.pos_y <= py; vtx_in.pos_z <= pz;
    vtx_in.tex_u <= tu; vtx_in.tex_v <= tv; vtx_in.has_normal <= hn;
    vtx_in.norm_in_x <= nx; vtx_in.norm_in_y <= ny; vtx_in.norm_in_z <= nz;
    @(posedge clk);
    while (!vtx_in.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic random_vertex(int style);
    send_vertex(rand_word(style), rand_word(style), rand_word(style), rand_word(style),
                rand_word(style), $urandom_range(0, 3) != 0, 16'($urandom), 16'($urandom),
                16'($urandom));
  endtask

  initial begin
    vtx_out.ready = 0;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        vtx_out.ready <= 0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      vtx_out.ready <= 1;
      @(negedge clk);
    end
  end

  initial begin
    #50ms;
    $display("timeout with %0d results outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    sent = 0;
    calm = 0;
    rst = 1;
    vtx_in.valid = 0;
    vtx_in.pos_x = 0; vtx_in.pos_y = 0; vtx_in.pos_z = 0;
    vtx_in.tex_u = 0; vtx_in.tex_v = 0; vtx_in.has_normal = 0;
    vtx_in.norm_in_x = 0; vtx_in.norm_in_y = 0; vtx_in.norm_in_z = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;
    // unit right triangle with supplied normals
    send_vertex(0, 0, 0, 0, 0, 1, 0, 0, 16384);
    send_vertex(32'h10000, 0, 0, 32'h10000, 0, 1, 0, 0, 16384);
    send_vertex(0, 32'h10000, 0, 0, 32'h10000, 1, 16'h8000, 16'h7fff, 16'hffff);
    // same triangle, face normal needed, flipped uv winding
    send_vertex(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_vertex(32'h10000, 0, 0, 0, 32'h10000, 1, 0, 0, 0);
    send_vertex(0, 32'h10000, 0, 32'h10000, 0, 1, 0, 0, 0);
    // collapsed triangle with a zero perp-dot
    send_vertex(0, 0, 0, 5, 5, 0, 0, 0, 0);
    send_vertex(7, 7, 7, 5, 5, 0, 0, 0, 0);
    send_vertex(7, 7, 7, 5, 5, 0, 0, 0, 0);
    // extreme corners
    send_vertex(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 1,
                16'h7fff, 16'h8000, 16'h7fff);
    send_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0,
                16'h8000, 16'h7fff, 16'h8000);
    send_vertex(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000, 1,
                16'hffff, 16'h0000, 16'h0001);
    // last corner alone lacks a normal
    send_vertex(32'hffffffff, 0, 1, 3, 9, 1, 1, 2, 3);
    send_vertex(0, 32'hfffff000, 0, 32'hffff0000, 1, 1, 4, 5, 6);
    send_vertex(32'h00123456, 0, 32'hfedcba98, 2, 32'hffffff00, 0, 7, 8, 9);
    while (sent < 400) begin
      if (sent == 201) begin
        vtx_in.valid <= 0;
        wait (pending == 0);
        @(negedge clk);
      end
      random_vertex($urandom_range(0, 3));
    end
    calm = 1;
    while (sent < 510) random_vertex($urandom_range(0, 3));
    vtx_in.valid <= 0;
    wait (pending == 0);
    repeat (300) @(posedge clk);
    $display("%0d vertices sent, %0d triangle vertices checked", sent, vertex_total);
    $display("stimulus: extreme and degenerate triangles, random mixes of normals and stalls");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
